// ===== sv/bclp_pkg.sv =====
package bclp_pkg;

    // width of stored timestamps; differences wrap modulo 2**TIME_BITS
    localparam int TIME_BITS_DEFAULT = 32;

    localparam int NOW_BITS    = 32;
    localparam int THRESH_BITS = 16;
    localparam int COUNT_BITS  = 8;

    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 16;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = 16'd5000;
    localparam logic [THRESH_BITS-1:0] CLICK_GAP_RESET  = 16'd100;
    localparam logic [THRESH_BITS-1:0] DEBOUNCE_RESET   = 16'd10;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'd255;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_LONG_PRESS = 2'd0,
        REG_CLICK_GAP  = 2'd1,
        REG_DEBOUNCE   = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                  long_press;
        logic                  clicks_ready;
        logic [COUNT_BITS-1:0] click_groups;
    } result_t;

endpackage

// ===== sv/button_click_long_press_classifier.sv =====
// Push-button click and long-press classifier. Each request on the s_axis side is one
// sample of the button level with a wrapping millisecond timestamp, and each produces
// exactly one result on the m_axis side: a long-press flag, a click-group-ended flag and
// the number of clicks in that group. The block takes one sample per clock unless the output
// stalls it; a sample sits in an input register, is classified by a few subtract-and-compare
// paths against the stored press/release times, and lands in the result register. Both
// registers advance whenever the result register is empty or being taken, so a full rate
// stream flows with no bubbles. Thresholds are written over the APB port
// (0x0 long_press_ms, 0x4 click_gap_ms, 0x8 debounce_ms, 16 bits each) and must be
// written only while no sample is in flight; the block itself does not enforce this.
module button_click_long_press_classifier #(
    parameter int TIME_BITS = bclp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] button_pressed, [32:1] now_ms, [39:33] zero
    input  logic [bclp_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] long_press, [1] clicks_ready, [9:2] click_groups, [15:10] zero
    output logic [bclp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bclp_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bclp_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bclp_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int TB = bclp_pkg::THRESH_BITS;
    localparam int CB = bclp_pkg::COUNT_BITS;

    logic [TB-1:0] long_press_ms_reg;
    logic [TB-1:0] click_gap_ms_reg;
    logic [TB-1:0] debounce_ms_reg;

    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic [TIME_BITS-1:0] in_now_reg;

    logic                 last_level_reg,   last_level_next;
    logic [TIME_BITS-1:0] press_time_reg,   press_time_next;
    logic [TIME_BITS-1:0] release_time_reg, release_time_next;
    logic [CB-1:0]        edge_count_reg,   edge_count_next;

    logic                 out_valid_reg;
    bclp_pkg::result_t    out_reg, out_next;

    logic                 advance;
    logic                 wr_en;
    bclp_pkg::reg_idx_t   wr_idx;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] since_release;
    logic [TIME_BITS-1:0] long_press_ext;
    logic [TIME_BITS-1:0] click_gap_ext;
    logic [TIME_BITS-1:0] debounce_ext;
    logic [CB-1:0]        count_bumped;
    logic [CB:0]          count_plus_one;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = bclp_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_ms_reg <= bclp_pkg::LONG_PRESS_RESET;
            click_gap_ms_reg  <= bclp_pkg::CLICK_GAP_RESET;
            debounce_ms_reg   <= bclp_pkg::DEBOUNCE_RESET;
        end else if (wr_en) begin
            case (wr_idx)
                bclp_pkg::REG_LONG_PRESS: long_press_ms_reg <= pwdata[TB-1:0];
                bclp_pkg::REG_CLICK_GAP:  click_gap_ms_reg  <= pwdata[TB-1:0];
                bclp_pkg::REG_DEBOUNCE:   debounce_ms_reg   <= pwdata[TB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            bclp_pkg::REG_LONG_PRESS: prdata = 32'(long_press_ms_reg);
            bclp_pkg::REG_CLICK_GAP:  prdata = 32'(click_gap_ms_reg);
            bclp_pkg::REG_DEBOUNCE:   prdata = 32'(debounce_ms_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_level_reg <= s_axis_tdata[0];
            in_now_reg   <= TIME_BITS'(s_axis_tdata[bclp_pkg::NOW_BITS:1]);
        end
    end

    // ---------------- classification ----------------
    assign since_press    = in_now_reg - press_time_reg;
    assign since_release  = in_now_reg - release_time_reg;
    assign long_press_ext = TIME_BITS'(long_press_ms_reg);
    assign click_gap_ext  = TIME_BITS'(click_gap_ms_reg);
    assign debounce_ext   = TIME_BITS'(debounce_ms_reg);
    assign count_bumped   = (edge_count_reg == bclp_pkg::COUNT_MAX) ?
                            edge_count_reg : edge_count_reg + 1'b1;
    assign count_plus_one = {1'b0, edge_count_reg} + 1'b1;

    always_comb begin
        last_level_next   = last_level_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        edge_count_next   = edge_count_reg;
        out_next          = '0;
        if (in_level_reg == last_level_reg) begin
            if (in_level_reg) begin
                out_next.long_press = (since_press >= long_press_ext);
            end else if (edge_count_reg != '0 && since_release > click_gap_ext) begin
                out_next.clicks_ready = 1'b1;
                out_next.click_groups = count_plus_one[CB:1];
                edge_count_next       = '0;
            end
        end else begin
            last_level_next = in_level_reg;
            if (in_level_reg) begin
                press_time_next = in_now_reg;
                if (since_release > debounce_ext) begin
                    edge_count_next = count_bumped;
                end
            end else begin
                release_time_next = in_now_reg;
                // only a short, debounced press counts as a click
                if (since_press > debounce_ext && since_press <= click_gap_ext) begin
                    edge_count_next = count_bumped;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg   <= 1'b0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            edge_count_reg   <= '0;
        end else if (advance && in_valid_reg) begin
            last_level_reg   <= last_level_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            edge_count_reg   <= edge_count_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.click_groups, out_reg.clicks_ready,
                            out_reg.long_press};

endmodule

// ===== tb/button_click_long_press_classifier_tb.sv =====
module button_click_long_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit        pressed;
        bit [31:0] now_ms;
    } sample_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // [0] button_pressed, [32:1] now_ms, [39:33] zero
    logic [bclp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata  = '0;

    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [0] long_press, [1] clicks_ready, [9:2] click_groups, [15:10] zero
    logic [bclp_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;

    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [bclp_pkg::APB_ADDR_BITS-1:0]  paddr   = '0;
    logic [bclp_pkg::APB_DATA_BITS-1:0]  pwdata  = '0;
    logic [bclp_pkg::APB_DATA_BITS-1:0]  prdata;
    logic                                pready;

    button_click_long_press_classifier dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    // thresholds as the block should hold them
    bit [bclp_pkg::THRESH_BITS-1:0] lp_ms  = bclp_pkg::LONG_PRESS_RESET;
    bit [bclp_pkg::THRESH_BITS-1:0] gap_ms = bclp_pkg::CLICK_GAP_RESET;
    bit [bclp_pkg::THRESH_BITS-1:0] deb_ms = bclp_pkg::DEBOUNCE_RESET;

    // button history as the block should track it
    bit                            btn_level  = 1'b0;
    bit [31:0]                     press_ms   = '0;
    bit [31:0]                     release_ms = '0;
    bit [bclp_pkg::COUNT_BITS-1:0] edge_cnt   = '0;

    sample_t           sample_q[$];
    bclp_pkg::result_t verdict_q[$];
    sample_t           offered;

    bit        steady_flow = 1'b0;
    logic      rx_choke    = 1'b0;
    bit [31:0] t_ms        = '0;
    int        send_wait, take_wait;
    int        queued_cnt, accepted_cnt, results_seen, lp_seen, groups_seen, biggest_group;
    int        errors;

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void classify_sample(input sample_t s);
        bclp_pkg::result_t r;
        bit [31:0]         since_press, since_release;
        r = '0;
        since_press   = s.now_ms - press_ms;
        since_release = s.now_ms - release_ms;
        if (s.pressed == btn_level) begin
            if (s.pressed) begin
                if (since_press >= {16'h0, lp_ms})
                    r.long_press = 1'b1;
            end else if (edge_cnt != 0 && since_release > {16'h0, gap_ms}) begin
                r.clicks_ready = 1'b1;
                r.click_groups = 8'((int'(edge_cnt) + 1) / 2);
                edge_cnt       = '0;
            end
        end else begin
            btn_level = s.pressed;
            if (s.pressed) begin
                press_ms = s.now_ms;
                // press too soon after the last release is a bounce
                if (since_release > {16'h0, deb_ms} && edge_cnt != bclp_pkg::COUNT_MAX)
                    edge_cnt++;
            end else begin
                release_ms = s.now_ms;
                if (since_press > {16'h0, deb_ms} && since_press <= {16'h0, gap_ms}
                        && edge_cnt != bclp_pkg::COUNT_MAX)
                    edge_cnt++;
            end
        end
        verdict_q.push_back(r);
    endfunction

    task automatic check_result(input logic [bclp_pkg::OUT_DATA_BITS-1:0] d);
        bclp_pkg::result_t want;
        results_seen++;
        if (verdict_q.size() == 0) begin
            log_mismatch($sformatf("result 0x%h with no request pending", d));
        end else begin
            want = verdict_q.pop_front();
            if (d[0] !== want.long_press)
                log_mismatch($sformatf("long_press %b, want %b", d[0], want.long_press));
            if (d[1] !== want.clicks_ready)
                log_mismatch($sformatf("clicks_ready %b, want %b", d[1], want.clicks_ready));
            if (d[9:2] !== want.click_groups)
                log_mismatch($sformatf("click_groups %0d, want %0d", d[9:2],
                                       want.click_groups));
            lp_seen     += want.long_press;
            groups_seen += want.clicks_ready;
            if (want.click_groups > biggest_group)
                biggest_group = want.click_groups;
        end
    endtask

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                classify_sample(offered);
                accepted_cnt++;
                if (accepted_cnt % 64 == 0)
                    steady_flow <= ($urandom_range(0, 3) == 0);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    offered = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(bclp_pkg::IN_DATA_BITS - 33){1'b0}}, offered.now_ms,
                                      offered.pressed};
                    send_wait = steady_flow ? 0 : $urandom_range(0, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                take_wait = steady_flow ? 0 : $urandom_range(0, 8);
            end else if (take_wait != 0) begin
                take_wait--;
            end
            m_axis_tready <= (take_wait == 0) && !rx_choke;
        end
    end

    // long receiver stall while requests keep coming, so the pipe backs up
    initial begin : rx_hold_off
        for (int k = 1; k <= 2; k++) begin
            wait (accepted_cnt >= 500 * k);
            @(posedge aclk);
            rx_choke <= 1'b1;
            repeat (80) @(posedge aclk);
            rx_choke <= 1'b0;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic push_sample(input bit pressed, input bit [31:0] now);
        sample_t s;
        s.pressed = pressed;
        s.now_ms  = now;
        sample_q.push_back(s);
        queued_cnt++;
    endtask

    task automatic reg_write(input bclp_pkg::reg_idx_t idx,
                             input bit [bclp_pkg::THRESH_BITS-1:0] value);
        logic [bclp_pkg::APB_DATA_BITS-1:0] rd;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            bclp_pkg::REG_LONG_PRESS: lp_ms  = value;
            bclp_pkg::REG_CLICK_GAP:  gap_ms = value;
            bclp_pkg::REG_DEBOUNCE:   deb_ms = value;
            default: ;
        endcase
        if (idx != bclp_pkg::REG_UNUSED) begin
            @(posedge aclk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            rd = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            if (rd[15:0] !== value)
                log_mismatch($sformatf("register %s reads 0x%h, want 0x%h", idx.name(),
                                       rd[15:0], value));
        end
    endtask

    task automatic settle();
        while (sample_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // a span that sits on or near the debounce and click-gap limits
    function automatic int unsigned near_limits();
        case ($urandom_range(0, 5))
            0: return deb_ms;
            1: return deb_ms + 1;
            2: return gap_ms;
            3: return gap_ms + 1;
            default: return (deb_ms < gap_ms) ? $urandom_range(deb_ms + 1, gap_ms)
                                              : $urandom_range(0, gap_ms + 1);
        endcase
    endfunction

    task automatic emit_clicks(input int clicks);
        bit [31:0] pressed_at;
        for (int c = 0; c < clicks; c++) begin
            t_ms += near_limits();
            push_sample(1'b1, t_ms);
            pressed_at = t_ms;
            t_ms += near_limits();
            if ($urandom_range(0, 3) == 0)
                push_sample(1'b1, pressed_at + (t_ms - pressed_at) / 2);
            push_sample(1'b0, t_ms);
            if ($urandom_range(0, 4) == 0)
                push_sample(1'b0, t_ms + $urandom_range(0, gap_ms));
        end
        // close the group, sometimes probing exactly at the gap first
        if ($urandom_range(0, 2) == 0)
            push_sample(1'b0, t_ms + gap_ms);
        t_ms += gap_ms + 1 + $urandom_range(0, 500);
        push_sample(1'b0, t_ms);
    endtask

    task automatic emit_long_hold();
        bit [31:0] pressed_at;
        t_ms += near_limits();
        push_sample(1'b1, t_ms);
        pressed_at = t_ms;
        if (lp_ms != 0)
            push_sample(1'b1, pressed_at + lp_ms - 1);
        push_sample(1'b1, pressed_at + lp_ms);
        push_sample(1'b1, pressed_at + lp_ms + $urandom_range(1, 3000));
        t_ms = pressed_at + lp_ms + $urandom_range(3001, 6000);
        push_sample(1'b0, t_ms);
    endtask

    task automatic emit_bounce();
        int n;
        bit lvl;
        n   = 2 * $urandom_range(1, 4);
        lvl = 1'b1;
        repeat (n) begin
            t_ms += $urandom_range(0, deb_ms);
            push_sample(lvl, t_ms);
            lvl = ~lvl;
        end
        t_ms += gap_ms + 1;
        push_sample(1'b0, t_ms);
    endtask

    task automatic emit_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0)
                t_ms = $urandom();
            else
                t_ms += $urandom_range(0, 2 * gap_ms + 2);
            push_sample(1'($urandom_range(0, 1)), t_ms);
        end
    endtask

    initial begin : stimulus
        int start;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset thresholds: 5000 long press, 100 gap, 10 debounce
        push_sample(1'b0, 32'd0);            // long release with nothing counted
        push_sample(1'b1, 32'd5);            // press inside debounce
        push_sample(1'b0, 32'd10);           // release of a too short press
        push_sample(1'b1, 32'd21);
        push_sample(1'b1, 32'd60);
        push_sample(1'b0, 32'd121);          // press exactly at the gap still counts
        push_sample(1'b0, 32'd221);          // gap not yet exceeded
        push_sample(1'b0, 32'd222);          // group ends, one click
        push_sample(1'b1, 32'd300);
        push_sample(1'b0, 32'd401);          // press over the gap is not a click
        push_sample(1'b0, 32'd600);          // odd count rounds up
        push_sample(1'b1, 32'd1000);
        push_sample(1'b1, 32'd5999);
        push_sample(1'b1, 32'd6000);         // long press exactly at the limit
        push_sample(1'b1, 32'd6001);
        push_sample(1'b0, 32'hFFFF_FFFF);
        push_sample(1'b1, 32'h0000_0005);    // debounce across the wrap
        push_sample(1'b0, 32'h0000_0040);
        push_sample(1'b0, 32'h8000_0000);
        push_sample(1'b1, 32'h8000_0000);
        push_sample(1'b1, 32'h7FFF_FFFF);    // sample in the past reads as far ahead
        push_sample(1'b0, 32'hFFFF_FFFE);
        push_sample(1'b0, 32'h0000_0000);
        settle();

        // hammer the count past its ceiling
        reg_write(bclp_pkg::REG_LONG_PRESS, 16'hFFFF);
        reg_write(bclp_pkg::REG_CLICK_GAP, 16'hFFFF);
        reg_write(bclp_pkg::REG_DEBOUNCE, 16'h0000);
        t_ms = 32'h0010_0000;
        push_sample(1'b0, t_ms);
        for (int k = 0; k < 300; k++) begin
            t_ms += 1;
            push_sample(~k[0], t_ms);
        end
        push_sample(1'b0, t_ms + 32'd65535);
        t_ms += 32'd65536;
        push_sample(1'b0, t_ms);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    reg_write(bclp_pkg::REG_LONG_PRESS, 16'd200);
                    reg_write(bclp_pkg::REG_CLICK_GAP, 16'd50);
                    reg_write(bclp_pkg::REG_DEBOUNCE, 16'd5);
                end
                1: begin
                    reg_write(bclp_pkg::REG_LONG_PRESS, 16'd0);
                    reg_write(bclp_pkg::REG_CLICK_GAP, 16'd0);
                    reg_write(bclp_pkg::REG_DEBOUNCE, 16'd0);
                end
                2: begin
                    reg_write(bclp_pkg::REG_LONG_PRESS, 16'hFFFF);
                    reg_write(bclp_pkg::REG_CLICK_GAP, 16'hFFFF);
                    reg_write(bclp_pkg::REG_DEBOUNCE, 16'hFFFF);
                    t_ms = 32'hFFFF_0000;
                end
                3: begin
                    reg_write(bclp_pkg::REG_LONG_PRESS, 16'($urandom_range(0, 65535)));
                    reg_write(bclp_pkg::REG_CLICK_GAP, 16'($urandom_range(0, 65535)));
                    reg_write(bclp_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 65535)));
                    reg_write(bclp_pkg::REG_UNUSED, 16'($urandom_range(0, 65535)));
                end
                default: begin
                    reg_write(bclp_pkg::REG_LONG_PRESS, 16'($urandom_range(50, 3000)));
                    reg_write(bclp_pkg::REG_CLICK_GAP, 16'($urandom_range(20, 400)));
                    reg_write(bclp_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 30)));
                end
            endcase
            start = queued_cnt;
            while (queued_cnt - start < 170) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: emit_clicks($urandom_range(1, 6));
                    5, 6:          emit_long_hold();
                    7, 8:          emit_noise();
                    default:       emit_bounce();
                endcase
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        $display("%0d samples sent, %0d results checked: %0d long-press flags, %0d groups",
                 accepted_cnt, results_seen, lp_seen, groups_seen);
        $display("largest group %0d clicks; reset, extreme and random thresholds, wrap",
                 biggest_group);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bclp_pkg.sv
sv/button_click_long_press_classifier.sv
tb/button_click_long_press_classifier_tb.sv
